### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define GAB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never shows outside reset.
`define GAB_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/gab_pkg.sv
package gab_pkg;

	// Input transaction: one mask sample and the pixel it lands on.
	typedef struct packed {
		logic [7:0]  mask_sample;
		logic [31:0] dest_pixel;
	} in_t;

	// Output transaction: the pixel to store and its write flag.
	typedef struct packed {
		logic [31:0] new_pixel;
		logic        write_enable;
	} out_t;

	// Per-pixel mode decoded at entry and carried down the pipe.
	typedef struct packed {
		logic wr;
		logic blend;
	} ctl_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_TINT_COLOR   = 2'd0;
	localparam logic [1:0] REG_BLEND_ENABLE = 2'd1;
	localparam logic [1:0] REG_MASK_FORMAT  = 2'd2;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	// Mask formats; code 3 is treated like FMT_NONE.
	typedef enum logic [1:0] {
		FMT_A8   = 2'd0,
		FMT_A1   = 2'd1,
		FMT_NONE = 2'd2
	} mask_fmt_t;

	localparam logic [31:0] TINT_RESET  = 32'hFFFF_FFFF;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

endpackage

### rtl/gab_mix.sv
module gab_mix (
	input  logic [7:0] d,
	input  logic [7:0] t,
	input  logic [7:0] a,
	output logic [7:0] d_part,
	output logic [7:0] t_part
);
	import gab_pkg::*;

	logic [7:0]  inv_a;
	logic [15:0] d_prod;
	logic [15:0] t_prod;

	// Weight the destination by the complement, the tint by the alpha, each >>8.
	assign inv_a  = ALPHA_OPAQUE - a;
	assign d_prod = d * inv_a;
	assign t_prod = t * a;
	assign d_part = d_prod[15:8];
	assign t_part = t_prod[15:8];

endmodule

### rtl/glyph_alpha_blend_pixel.sv
// An accepted input passes stage 1, stage 2 and the output register.
// Throughput: one transaction per cycle; each stage holds only while its
//   successor is full and stalled, so bubbles collapse.
// The output register keeps a result while the next ones move up behind it.
// Reset (arst_n low, asynchronous): pipe empties, tint = 0xFFFFFFFF,
//   blend on, eight-bit mask format.
module glyph_alpha_blend_pixel (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  gab_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output gab_pkg::out_t                   out_data,
	input  logic                            cfg_we,
	input  logic [gab_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [gab_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import gab_pkg::*;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [31:0] tint_q;
	logic        blend_q;
	logic [1:0]  fmt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_q  <= TINT_RESET;
			blend_q <= 1'b1;
			fmt_q   <= FMT_A8;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TINT_COLOR:   tint_q  <= cfg_data;
				REG_BLEND_ENABLE: blend_q <= cfg_data[0];
				REG_MASK_FORMAT:  fmt_q   <= cfg_data[1:0];
				default:          ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Flow control: a stage may load when it is empty or its
	// successor loads in the same cycle.
	// ---------------------------------------------------------------
	logic v_s1, v_s2;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3   = !out_valid || !out_stall;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// ---------------------------------------------------------------
	// Stage 1: decode mode, scale the tint alpha by coverage (A8 only) and
	// build the overwrite pixel for non-blend mode.
	// ---------------------------------------------------------------
	logic [7:0]  m;
	logic [15:0] sa_prod;
	logic [7:0]  src_a;
	logic [31:0] scaled;
	ctl_t        ctl;

	assign m       = in_data.mask_sample;
	assign sa_prod = m * tint_q[31:24];

	always_comb begin
		ctl.wr    = 1'b0;
		ctl.blend = 1'b0;
		case (fmt_q)
			FMT_A8: begin
				ctl.blend = blend_q;
				ctl.wr    = !blend_q || (m != 8'd0);
			end
			FMT_A1: begin
				ctl.blend = 1'b1;
				ctl.wr    = blend_q && m[0];
			end
			default: ;
		endcase
	end

	// One-bit blend takes the tint alpha unscaled.
	assign src_a = (fmt_q == FMT_A8) ? sa_prod[15:8] : tint_q[31:24];

	always_comb begin
		logic [15:0] p;
		for (int k = 0; k < 4; k++) begin
			p = tint_q[8*k +: 8] * m;
			scaled[8*k +: 8] = p[15:8];
		end
	end

	ctl_t        ctl_s1;
	logic [7:0]  src_a_s1;
	logic [31:0] dest_s1;
	logic [31:0] scaled_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			ctl_s1    <= ctl;
			src_a_s1  <= src_a;
			dest_s1   <= in_data.dest_pixel;
			scaled_s1 <= scaled;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: pick the mix alpha (opaque over a clear destination),
	// form the six weighted products and the saturated alpha.
	// ---------------------------------------------------------------
	logic [7:0]       da;
	logic [7:0]       mix_a;
	logic [8:0]       a_sum;
	logic [7:0]       a_sat;
	logic [2:0][7:0]  d_part;
	logic [2:0][7:0]  t_part;

	assign da    = dest_s1[31:24];
	assign mix_a = (da == 8'd0) ? ALPHA_OPAQUE : src_a_s1;
	assign a_sum = {1'b0, da} + {1'b0, src_a_s1};
	assign a_sat = a_sum[8] ? ALPHA_OPAQUE : a_sum[7:0];

	for (genvar c = 0; c < 3; c++) begin : g_chan
		gab_mix u_mix (
			.d      (dest_s1[8*c +: 8]),
			.t      (tint_q[8*c +: 8]),
			.a      (mix_a),
			.d_part (d_part[c]),
			.t_part (t_part[c])
		);
	end

	ctl_t            ctl_s2;
	logic [2:0][7:0] d_part_s2;
	logic [2:0][7:0] t_part_s2;
	logic [7:0]      alpha_s2;
	logic [31:0]     scaled_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			ctl_s2    <= ctl_s1;
			d_part_s2 <= d_part;
			t_part_s2 <= t_part;
			alpha_s2  <= a_sat;
			scaled_s2 <= scaled_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: add the weighted halves and assemble the pixel. The
	// two halves never sum past 254, so each channel fits a byte.
	// Drop the pixel to zero when nothing is written.
	// ---------------------------------------------------------------
	logic [31:0] blended;
	logic [31:0] px;

	always_comb begin
		blended[31:24] = alpha_s2;
		for (int c = 0; c < 3; c++) begin
			blended[8*c +: 8] = d_part_s2[c] + t_part_s2[c];
		end
	end

	always_comb begin
		px = 32'd0;
		if (ctl_s2.wr) begin
			px = ctl_s2.blend ? blended : scaled_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s3) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			out_data.new_pixel    <= px;
			out_data.write_enable <= ctl_s2.wr;
		end
	end

endmodule

### rtl/gab_checker.sv
`include "assert_macros.svh"

module gab_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input gab_pkg::out_t                   out_data
);
	import gab_pkg::*;

	// A transaction without a write carries a zero pixel.
	`GAB_NEVER(a_nowrite_zero, out_valid && !out_data.write_enable && (out_data.new_pixel != 32'd0), "pixel not zero on a no-write result")

	// The input side only backs up when the whole pipe is full and blocked.
	`GAB_ASSERT(a_stall_full, in_stall |-> (out_valid && out_stall), "input stalled while output can drain")

	// An accepted transaction reaches the output while out_stall stays low.
	`GAB_ASSERT(a_latency, (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall |=> out_valid, "result missing after three cycles")

	// A stalled result holds.
	`GAB_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "stalled output changed")

endmodule

bind glyph_alpha_blend_pixel gab_checker u_gab_checker (.*);
